>>> rtl/core/snpd_pkg.sv
// ----------------------------------------------------------------------------
// snpd_pkg
// Shared constants and types for the sync-header packet deframer.
// ----------------------------------------------------------------------------
package snpd_pkg;

  // largest number of data words one packet may carry
  localparam int unsigned MAX_WORDS = 15;
  localparam int unsigned IDX_W     = 4;
  // two banks of word storage, one being filled while the other drains
  localparam int unsigned RAM_AW    = IDX_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** RAM_AW;
  localparam int unsigned WORD_W    = 32;

  // header bytes 's','n','p' and their 16-bit sum
  localparam logic [23:0] HDR_PATTERN = 24'h736E70;
  localparam logic [15:0] HDR_SUM     = 16'h0073 + 16'h006E + 16'h0070;

  // frame lengths in bytes
  localparam logic [6:0] LEN_BASE = 7'd7;
  localparam logic [6:0] LEN_ONE  = 7'd11;

  // kind of packet given by type bits 7..6
  typedef enum logic [1:0] {
    KIND_NONE  = 2'b00,
    KIND_BAD   = 2'b01,
    KIND_DATA  = 2'b10,
    KIND_BATCH = 2'b11
  } kind_e;

  // packet handed from the front end to the back end
  typedef struct packed {
    logic             bank;
    logic [7:0]       ptype;
    logic [7:0]       addr;
    logic [IDX_W-1:0] nwords;
  } desc_t;

  // word store write port
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } ram_wr_t;

  // word store read port
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
  } ram_rd_t;

  // bank release from the back end
  typedef struct packed {
    logic done;
    logic bank;
  } drain_t;

endpackage

>>> rtl/core/snpd_if.sv
// ----------------------------------------------------------------------------
// snpd_if
// Valid/ready channels for received bytes and deframed result words.
// ----------------------------------------------------------------------------
interface snpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface snpd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  packet_type;
  logic [7:0]  register_address;
  logic [31:0] data_word;
  logic [3:0]  word_index;
  logic        carries_data;
  logic        last_word;

  modport source (
    output valid, output packet_type, output register_address, output data_word,
    output word_index, output carries_data, output last_word, input ready
  );
  modport sink (
    input valid, input packet_type, input register_address, input data_word,
    input word_index, input carries_data, input last_word, output ready
  );
endinterface

>>> rtl/core/snpd_ram.sv
// ----------------------------------------------------------------------------
// snpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module snpd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

>>> rtl/core/snpd_front.sv
// ----------------------------------------------------------------------------
// snpd_front
// Header search, framing, running sum and word assembly for received bytes.
// ----------------------------------------------------------------------------
module snpd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  snpd_byte_if.sink        in_i,
  input  snpd_pkg::drain_t drain_i,
  output snpd_pkg::ram_wr_t wr_o,
  output logic             push_o,
  output snpd_pkg::desc_t  desc_o
);
  import snpd_pkg::*;

  logic              in_frame_q, in_frame_d;
  logic [23:0]       hist_q, hist_d;
  logic [6:0]        pos_q, pos_d;
  logic              bank_q, bank_d;
  logic [1:0]        busy_q, busy_d;
  logic [6:0]        len_q;
  logic [IDX_W-1:0]  n_q;
  logic [15:0]       sum_q;
  logic [7:0]        type_q;
  logic [7:0]        addr_q;
  logic [7:0]        shi_q;
  logic [23:0]       asm_q;

  logic              acc;
  logic [7:0]        b;
  logic              hdr_len_ok;
  logic [6:0]        hdr_len;
  logic [IDX_W-1:0]  hdr_n;
  logic              hdr_hit;
  logic              is_end;
  logic              is_hi;
  logic              is_data;
  logic [6:0]        off;
  logic              sum_match;

  assign acc = in_i.valid && in_i.ready;
  assign b   = in_i.rx_byte;

  // stall only while the bank being filled still drains
  assign in_i.ready = !(in_frame_q && busy_q[bank_q]);

  // frame length from the type byte
  always_comb begin
    hdr_len_ok = 1'b1;
    hdr_len    = LEN_BASE;
    hdr_n      = '0;
    unique case (kind_e'(b[7:6]))
      KIND_BATCH: begin
        hdr_n   = b[5:2];
        hdr_len = LEN_BASE + {1'b0, b[5:2], 2'b00};
      end
      KIND_DATA: begin
        hdr_n   = IDX_W'(1);
        hdr_len = LEN_ONE;
      end
      KIND_NONE: begin
        hdr_n   = '0;
        hdr_len = LEN_BASE;
      end
      default: begin
        hdr_len_ok = 1'b0;
      end
    endcase
  end

  assign hdr_hit = (hist_q == HDR_PATTERN) && hdr_len_ok
                   && ({1'b0, hdr_n} <= (IDX_W + 1)'(MAX_WORDS));

  // position decode inside a frame
  assign is_end    = ({1'b0, pos_q} + 8'd1) >= {1'b0, len_q};
  assign is_hi     = ({1'b0, pos_q} + 8'd2) == {1'b0, len_q};
  assign off       = pos_q - 7'd5;
  assign is_data   = pos_q >= 7'd5;
  assign sum_match = {shi_q, b} == sum_q;

  // word store write on the fourth byte of each word
  always_comb begin
    wr_o.en   = acc && in_frame_q && !is_end && !is_hi && is_data && (off[1:0] == 2'b11);
    wr_o.addr = {bank_q, off[IDX_W+1:2]};
    wr_o.data = {asm_q, b};
  end

  // packet handoff on a matching checksum
  assign push_o = acc && in_frame_q && is_end && sum_match;
  always_comb begin
    desc_o.bank   = bank_q;
    desc_o.ptype  = type_q;
    desc_o.addr   = addr_q;
    desc_o.nwords = n_q;
  end

  // control next state
  always_comb begin
    in_frame_d = in_frame_q;
    hist_d     = hist_q;
    pos_d      = pos_q;
    bank_d     = bank_q;
    busy_d     = busy_q;
    if (drain_i.done) begin
      busy_d[drain_i.bank] = 1'b0;
    end
    if (push_o) begin
      busy_d[bank_q] = 1'b1;
      bank_d         = !bank_q;
    end
    if (acc) begin
      if (!in_frame_q) begin
        if (hdr_hit) begin
          in_frame_d = 1'b1;
          pos_d      = 7'd4;
        end
        hist_d = {hist_q[15:0], b};
      end else if (is_end) begin
        in_frame_d = 1'b0;
        pos_d      = '0;
        hist_d     = '0;
      end else begin
        pos_d = pos_q + 7'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      hist_q     <= '0;
      pos_q      <= '0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      hist_q     <= hist_d;
      pos_q      <= pos_d;
      bank_q     <= bank_d;
      busy_q     <= busy_d;
    end
  end

  // frame payload registers
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (!in_frame_q) begin
        if (hdr_hit) begin
          len_q  <= hdr_len;
          n_q    <= hdr_n;
          sum_q  <= HDR_SUM + {8'h00, b};
          type_q <= b;
          addr_q <= '0;
          shi_q  <= '0;
          asm_q  <= '0;
        end
      end else if (!is_end) begin
        if (is_hi) begin
          shi_q <= b;
        end else begin
          sum_q <= sum_q + {8'h00, b};
          if (pos_q == 7'd4) begin
            addr_q <= b;
          end else if (is_data) begin
            if (off[1:0] == 2'b11) begin
              asm_q <= '0;
            end else begin
              asm_q <= {asm_q[15:0], b};
            end
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/snpd_queue.sv
// ----------------------------------------------------------------------------
// snpd_queue
// Two-entry queue of finished packets between front end and back end.
// ----------------------------------------------------------------------------
module snpd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  snpd_pkg::desc_t desc_i,
  input  logic            pop_i,
  output logic            head_valid_o,
  output snpd_pkg::desc_t head_o
);
  import snpd_pkg::*;

  desc_t      slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign do_push      = push_i && (count_q != 2'd2);
  assign do_pop       = pop_i && (count_q != 2'd0);
  assign head_valid_o = count_q != 2'd0;
  assign head_o       = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

>>> rtl/core/snpd_back.sv
// ----------------------------------------------------------------------------
// snpd_back
// Reads the stored words of a finished packet and presents one result each, or a
// single empty result for a packet without data.
module snpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  snpd_result_if.source     out_o,
  input  logic              head_valid_i,
  input  snpd_pkg::desc_t   head_i,
  output logic              pop_o,
  output snpd_pkg::drain_t  drain_o,
  output snpd_pkg::ram_rd_t rd_o,
  input  logic [snpd_pkg::WORD_W-1:0] rd_data_i
);
  import snpd_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOAD,
    B_SHOW
  } state_e;

  state_e           state_q;
  logic [IDX_W-1:0] k_q;
  logic             valid_q;
  logic [7:0]       ptype_q;
  logic [7:0]       addr_q;
  logic [31:0]      data_q;
  logic [IDX_W-1:0] idx_q;
  logic             carries_q;
  logic             last_q;
  logic             taken;
  logic [IDX_W-1:0] k_next;

  assign taken  = (state_q == B_SHOW) && out_o.ready;
  assign k_next = k_q + IDX_W'(1);

  // bank release once the final word is taken
  assign pop_o        = taken && last_q;
  assign drain_o.done = pop_o;
  assign drain_o.bank = head_i.bank;

  // word store read
  always_comb begin
    rd_o.en   = 1'b0;
    rd_o.addr = {head_i.bank, k_q};
    unique case (state_q)
      B_IDLE: begin
        rd_o.en   = head_valid_i && (head_i.nwords != '0);
        rd_o.addr = {head_i.bank, {IDX_W{1'b0}}};
      end
      B_SHOW: begin
        rd_o.en   = taken && !last_q;
        rd_o.addr = {head_i.bank, k_next};
      end
      default: begin
        rd_o.en = 1'b0;
      end
    endcase
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_q <= 1'b0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (head_valid_i) begin
            k_q     <= '0;
            ptype_q <= head_i.ptype;
            addr_q  <= head_i.addr;
            if (head_i.nwords == '0) begin
              data_q    <= '0;
              idx_q     <= '0;
              carries_q <= 1'b0;
              last_q    <= 1'b1;
              valid_q   <= 1'b1;
              state_q   <= B_SHOW;
            end else begin
              state_q <= B_LOAD;
            end
          end
        end
        B_LOAD: begin
          data_q    <= rd_data_i;
          idx_q     <= k_q;
          carries_q <= 1'b1;
          last_q    <= (k_next == head_i.nwords);
          valid_q   <= 1'b1;
          state_q   <= B_SHOW;
        end
        B_SHOW: begin
          if (out_o.ready) begin
            valid_q <= 1'b0;
            if (last_q) begin
              state_q <= B_IDLE;
            end else begin
              k_q     <= k_next;
              state_q <= B_LOAD;
            end
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.packet_type      = ptype_q;
  assign out_o.register_address = addr_q;
  assign out_o.data_word        = data_q;
  assign out_o.word_index       = idx_q;
  assign out_o.carries_data     = carries_q;
  assign out_o.last_word        = last_q;

endmodule

>>> rtl/core/snp_packet_deframer_sum_check.sv
// ----------------------------------------------------------------------------
// snp_packet_deframer_sum_check
// Finds 's','n','p' framed packets in a byte stream, checks the 16-bit sum
// and emits one word per stored data word of each good packet (a single empty word for a packet without data).
// ----------------------------------------------------------------------------
// Input: one byte per cycle; a byte stalls only inside a frame whose word bank
//   still holds an earlier packet that has not fully drained.
// Output: after the checksum low byte each packet goes through the packet queue,
//   then a word store read and the output register per word (a packet without
//   data skips the read); the next word is read only once the last is taken.
// Reset: asynchronous; clears header search, framing, bank flags, queue and
//   output valid. Word storage needs no clearing.
module snp_packet_deframer_sum_check (
  input  logic          clk_i,
  input  logic          rst_ni,
  snpd_byte_if.sink     in_i,
  snpd_result_if.source out_o
);
  import snpd_pkg::*;

  ram_wr_t             wr;
  ram_rd_t             rd;
  logic [WORD_W-1:0]   rd_data;
  logic                push;
  desc_t               desc;
  logic                head_valid;
  desc_t               head;
  logic                pop;
  drain_t              drain;

  // framing front end
  snpd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .drain_i (drain),
    .wr_o    (wr),
    .push_o  (push),
    .desc_o  (desc)
  );

  // two banks of data words
  snpd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr.en),
    .wr_addr_i (wr.addr),
    .wr_data_i (wr.data),
    .rd_en_i   (rd.en),
    .rd_addr_i (rd.addr),
    .rd_data_o (rd_data)
  );

  // finished packet queue
  snpd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .desc_i       (desc),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // result back end
  snpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .out_o        (out_o),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .drain_o      (drain),
    .rd_o         (rd),
    .rd_data_i    (rd_data)
  );

endmodule

>>> rtl/core/snpd_checker.sv
// ----------------------------------------------------------------------------
// snpd_checker
// Port-level checks on the deframer result stream.
// ----------------------------------------------------------------------------
module snpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  packet_type_i,
  input logic [7:0]  register_address_i,
  input logic [31:0] data_word_i,
  input logic [3:0]  word_index_i,
  input logic        carries_data_i,
  input logic        last_word_i
);

  // a stalled word holds
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(data_word_i)
      && $stable(word_index_i) && $stable(last_word_i) && $stable(packet_type_i)
      && $stable(register_address_i) && $stable(carries_data_i))
    else $error("result word changed while stalled");

  // a packet without data gives a single empty word
  a_no_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !carries_data_i |-> last_word_i && (data_word_i == 32'd0)
      && (word_index_i == 4'd0)
      && (!packet_type_i[7] || (packet_type_i[5:2] == 4'd0)))
    else $error("bad empty result");

  // single-word data packet
  a_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && carries_data_i && !packet_type_i[6] |->
      packet_type_i[7] && (word_index_i == 4'd0) && last_word_i)
    else $error("bad single-word result");

  // batch packet index stays within its count and ends on the last word
  a_batch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && carries_data_i && packet_type_i[6] |->
      packet_type_i[7] && (word_index_i < packet_type_i[5:2])
      && (last_word_i == (word_index_i + 4'd1 == packet_type_i[5:2])))
    else $error("bad batch result index");

endmodule

bind snp_packet_deframer_sum_check snpd_checker u_snpd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .packet_type_i      (out_o.packet_type),
  .register_address_i (out_o.register_address),
  .data_word_i        (out_o.data_word),
  .word_index_i       (out_o.word_index),
  .carries_data_i     (out_o.carries_data),
  .last_word_i        (out_o.last_word)
);
